// ===== rtl/core/ldc_pkg.sv =====
// ----------------------------------------------------------------------------
// ldc_pkg: shared definitions of the locked descriptor cache
// Sizes, command codes, the request, response and entry records.
// ----------------------------------------------------------------------------
package ldc_pkg;

	localparam int ENTRIES      = 16;
	localparam int LOCK_BITS    = 16;
	localparam int RESULT_LIMIT = 16;

	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int RES_CNT_W = $clog2(RESULT_LIMIT + 1);

	localparam logic [2:0] CMD_LOOKUP     = 3'd0;
	localparam logic [2:0] CMD_INSERT     = 3'd1;
	localparam logic [2:0] CMD_RELEASE    = 3'd2;
	localparam logic [2:0] CMD_INVALIDATE = 3'd3;
	localparam logic [2:0] CMD_PURGE      = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] object_number;
		logic [7:0]  category;
		logic [7:0]  server_id;
		logic        match_any_object;
		logic [31:0] handle_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] handle_out;
		logic        stored;
		logic        free_valid;
		logic [31:0] free_handle;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0]          object;
		logic [7:0]           category;
		logic [7:0]           server;
		logic                 mark;
		logic [LOCK_BITS-1:0] lock;
		logic [31:0]          handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/ldc_if.sv =====
// ----------------------------------------------------------------------------
// ldc_if: request and response channels of the descriptor cache
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ldc_req_if;
	logic          valid;
	logic          ready;
	ldc_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ldc_rsp_if;
	logic          valid;
	logic          ready;
	ldc_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ldc_ram.sv =====
// ----------------------------------------------------------------------------
// ldc_ram: simple dual-port synchronous RAM
// One write port, one read port with registered data and a read enable.
// ----------------------------------------------------------------------------
module ldc_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ldc_out_reg.sv =====
// ----------------------------------------------------------------------------
// ldc_out_reg: response output register
// Holds one response beat and decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
module ldc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ldc_pkg::rsp_t     data,
	output logic              free,
	ldc_rsp_if.source         rsp
);

	logic          valid_q;
	ldc_pkg::rsp_t data_q;

	assign free        = !valid_q || rsp.ready;
	assign rsp.valid   = valid_q;
	assign rsp.payload = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

endmodule

// ===== rtl/core/ldc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldc_ctrl: command sequencer of the descriptor cache
// Scans the entry RAM once per command, then finishes with any write-back.
// ----------------------------------------------------------------------------
module ldc_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ldc_req_if.sink                              req,
	input  logic                                 out_free,
	output logic                                 res_load,
	output ldc_pkg::rsp_t                        res_data,
	output logic                                 mem_we,
	output logic [ldc_pkg::IDX_W-1:0]            mem_waddr,
	output logic [ldc_pkg::ENTRY_W-1:0]          mem_wdata,
	output logic                                 mem_re,
	output logic [ldc_pkg::IDX_W-1:0]            mem_raddr,
	input  logic [ldc_pkg::ENTRY_W-1:0]          mem_rdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

	state_t                          state_q;
	ldc_pkg::req_t                   cmd_q;
	logic [ldc_pkg::CNT_W-1:0]       idx_q;
	logic                            v_s1;
	logic [ldc_pkg::IDX_W-1:0]       idx_s1;
	logic [ldc_pkg::ENTRIES-1:0]     slot_valid_q;
	logic [ldc_pkg::IDX_W-1:0]       rr_q;
	logic [ldc_pkg::RES_CNT_W-1:0]   n_q;
	logic                            hit_found_q;
	logic [ldc_pkg::IDX_W-1:0]       hit_idx_q;
	ldc_pkg::entry_t                 hit_entry_q;
	logic                            free_found_q;
	logic [ldc_pkg::IDX_W-1:0]       free_idx_q;
	logic                            rr_found_q;
	logic [31:0]                     rr_handle_q;
	logic                            other_found_q;
	logic [ldc_pkg::IDX_W-1:0]       other_idx_q;
	logic [31:0]                     other_handle_q;
	logic                            matched_q;
	logic                            pend_v_q;
	logic [31:0]                     pend_handle_q;

	ldc_pkg::entry_t e;
	logic cur_valid, is_lk, key_m, rel_m, inv_m, inv_mark, inv_free;
	logic stall, advance, scan_end, eval, accept, finish;
	logic ins_have, ins_ev;
	logic [ldc_pkg::IDX_W-1:0] ins_idx;
	logic [31:0] ins_old;
	logic [ldc_pkg::LOCK_BITS-1:0] rel_lock;
	logic rel_freed;
	ldc_pkg::entry_t wentry;

	assign e         = ldc_pkg::entry_t'(mem_rdata);
	assign cur_valid = slot_valid_q[idx_s1];
	assign is_lk     = (cmd_q.command == ldc_pkg::CMD_LOOKUP) ||
	                   (cmd_q.command == ldc_pkg::CMD_INSERT);

	assign key_m = cur_valid && (e.object == cmd_q.object_number) &&
	               (e.category == cmd_q.category) && (e.server == cmd_q.server_id);
	assign rel_m = cur_valid && (e.handle == cmd_q.handle_in);
	always_comb begin
		inv_m = 1'b0;
		if (cur_valid && (e.server == cmd_q.server_id)) begin
			if (cmd_q.command == ldc_pkg::CMD_PURGE) begin
				inv_m = 1'b1;
			end else if (cmd_q.command == ldc_pkg::CMD_INVALIDATE) begin
				inv_m = (cmd_q.match_any_object || (e.object == cmd_q.object_number)) &&
				        (e.category == cmd_q.category);
			end
		end
	end
	assign inv_mark = inv_m && (cmd_q.command == ldc_pkg::CMD_INVALIDATE) && (e.lock != '0);
	assign inv_free = inv_m && !inv_mark && (n_q < ldc_pkg::RES_CNT_W'(ldc_pkg::RESULT_LIMIT));

	// A freed handle displaces the pending one into the output register.
	assign stall    = v_s1 && inv_free && pend_v_q && !out_free;
	assign advance  = (state_q == S_SCAN) && !stall;
	assign eval     = advance && v_s1;
	assign scan_end = advance && (idx_q == ldc_pkg::CNT_W'(ldc_pkg::ENTRIES));
	assign accept   = req.valid && req.ready;
	assign finish   = (state_q == S_FINISH) && out_free;

	assign req.ready = (state_q == S_IDLE);
	assign mem_re    = advance && (idx_q != ldc_pkg::CNT_W'(ldc_pkg::ENTRIES));
	assign mem_raddr = idx_q[ldc_pkg::IDX_W-1:0];

	// Slot choice for an insert miss.
	assign ins_have = free_found_q || rr_found_q || other_found_q;
	assign ins_ev   = !free_found_q;
	assign ins_idx  = free_found_q ? free_idx_q : (rr_found_q ? rr_q : other_idx_q);
	assign ins_old  = rr_found_q ? rr_handle_q : other_handle_q;

	assign rel_lock  = (hit_entry_q.lock != '0) ? hit_entry_q.lock - 1'b1 : hit_entry_q.lock;
	assign rel_freed = (rel_lock == '0) && hit_entry_q.mark;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		wentry    = e;
		res_load  = 1'b0;
		res_data  = '0;
		if (state_q == S_SCAN) begin
			if (eval && inv_mark) begin
				mem_we      = 1'b1;
				wentry.mark = 1'b1;
			end
			if (eval && inv_free && pend_v_q) begin
				res_load             = 1'b1;
				res_data.hit         = 1'b1;
				res_data.free_valid  = 1'b1;
				res_data.free_handle = pend_handle_q;
			end
		end else if (finish) begin
			res_load      = 1'b1;
			res_data.last = 1'b1;
			case (cmd_q.command)
				ldc_pkg::CMD_LOOKUP, ldc_pkg::CMD_INSERT: begin
					if (hit_found_q) begin
						mem_we    = 1'b1;
						mem_waddr = hit_idx_q;
						wentry    = hit_entry_q;
						if (hit_entry_q.lock != '1) begin
							wentry.lock = hit_entry_q.lock + 1'b1;
						end
						res_data.hit        = 1'b1;
						res_data.handle_out = hit_entry_q.handle;
						if (cmd_q.command == ldc_pkg::CMD_INSERT) begin
							res_data.free_valid  = 1'b1;
							res_data.free_handle = cmd_q.handle_in;
						end
					end else if (cmd_q.command == ldc_pkg::CMD_INSERT) begin
						res_data.handle_out = cmd_q.handle_in;
						if (ins_have) begin
							mem_we          = 1'b1;
							mem_waddr       = ins_idx;
							wentry.object   = cmd_q.object_number;
							wentry.category = cmd_q.category;
							wentry.server   = cmd_q.server_id;
							wentry.mark     = 1'b0;
							wentry.lock     = ldc_pkg::LOCK_BITS'(1);
							wentry.handle   = cmd_q.handle_in;
							res_data.stored      = 1'b1;
							res_data.free_valid  = ins_ev;
							res_data.free_handle = ins_ev ? ins_old : 32'd0;
						end
					end
				end
				ldc_pkg::CMD_RELEASE: begin
					if (hit_found_q) begin
						mem_we      = 1'b1;
						mem_waddr   = hit_idx_q;
						wentry      = hit_entry_q;
						wentry.lock = rel_lock;
						res_data.hit         = 1'b1;
						res_data.free_valid  = rel_freed;
						res_data.free_handle = rel_freed ? hit_entry_q.handle : 32'd0;
					end else begin
						res_data.free_valid  = 1'b1;
						res_data.free_handle = cmd_q.handle_in;
					end
				end
				ldc_pkg::CMD_INVALIDATE, ldc_pkg::CMD_PURGE: begin
					if (pend_v_q) begin
						res_data.hit         = 1'b1;
						res_data.free_valid  = 1'b1;
						res_data.free_handle = pend_handle_q;
					end else begin
						res_data.hit = matched_q;
					end
				end
				default: begin
					res_data.last = 1'b1;
				end
			endcase
		end
	end

	assign mem_wdata = wentry;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			v_s1          <= 1'b0;
			slot_valid_q  <= '0;
			rr_q          <= '0;
			n_q           <= '0;
			hit_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
			rr_found_q    <= 1'b0;
			other_found_q <= 1'b0;
			matched_q     <= 1'b0;
			pend_v_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q       <= S_SCAN;
						idx_q         <= '0;
						v_s1          <= 1'b0;
						n_q           <= '0;
						hit_found_q   <= 1'b0;
						free_found_q  <= 1'b0;
						rr_found_q    <= 1'b0;
						other_found_q <= 1'b0;
						matched_q     <= 1'b0;
						pend_v_q      <= 1'b0;
					end
				end
				S_SCAN: begin
					if (advance) begin
						v_s1 <= mem_re;
						if (mem_re) begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (eval) begin
						if (is_lk && key_m && !hit_found_q) begin
							hit_found_q <= 1'b1;
						end
						if (cmd_q.command == ldc_pkg::CMD_INSERT) begin
							if (!cur_valid) begin
								free_found_q <= 1'b1;
							end else if (e.lock == '0) begin
								if (idx_s1 == rr_q) begin
									rr_found_q <= 1'b1;
								end else begin
									other_found_q <= 1'b1;
								end
							end
						end
						if ((cmd_q.command == ldc_pkg::CMD_RELEASE) && rel_m) begin
							hit_found_q <= 1'b1;
						end
						if (inv_m) begin
							matched_q <= 1'b1;
						end
						if (inv_free) begin
							slot_valid_q[idx_s1] <= 1'b0;
							pend_v_q             <= 1'b1;
							n_q                  <= n_q + 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish) begin
						state_q <= S_IDLE;
						if ((cmd_q.command == ldc_pkg::CMD_INSERT) && !hit_found_q) begin
							if (!free_found_q) begin
								rr_q <= (rr_q == ldc_pkg::IDX_W'(ldc_pkg::ENTRIES - 1)) ?
								        '0 : rr_q + 1'b1;
							end
							if (ins_have) begin
								slot_valid_q[ins_idx] <= 1'b1;
							end
						end
						if ((cmd_q.command == ldc_pkg::CMD_RELEASE) && hit_found_q &&
						    rel_freed) begin
							slot_valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload captured during the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.payload;
		end
		if (advance) begin
			idx_s1 <= mem_raddr;
		end
		if (eval) begin
			if (is_lk && key_m && !hit_found_q) begin
				hit_idx_q   <= idx_s1;
				hit_entry_q <= e;
			end
			if ((cmd_q.command == ldc_pkg::CMD_RELEASE) && rel_m && !hit_found_q) begin
				hit_idx_q   <= idx_s1;
				hit_entry_q <= e;
			end
			if (!cur_valid) begin
				free_idx_q <= idx_s1;
			end else if (e.lock == '0) begin
				if (idx_s1 == rr_q) begin
					rr_handle_q <= e.handle;
				end else begin
					other_idx_q    <= idx_s1;
					other_handle_q <= e.handle;
				end
			end
			if (inv_free) begin
				pend_handle_q <= e.handle;
			end
		end
	end

	// The scan never writes the entry it is reading.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("entry RAM read and write hit the same address");

	// A response is loaded only when the output register can take it.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("response loaded into a full output register");

	// Nothing is left pending once the sequencer is back in idle.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(finish |=> (req.ready && !v_s1)))
		else $error("sequencer left finish without returning to idle");

	// The freed-handle count stays within the per-command limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= ldc_pkg::RES_CNT_W'(ldc_pkg::RESULT_LIMIT))
		else $error("freed-handle count passed its limit");

endmodule

// ===== rtl/core/locked_descriptor_cache.sv =====
// ----------------------------------------------------------------------------
// locked_descriptor_cache: lock-counted cache of descriptor handles
// Lookup, insert, release, invalidate and purge over a small entry RAM.
// ----------------------------------------------------------------------------
// The block takes one command beat on req and answers with one or more
// response beats on rsp; the final beat of a command carries last. Commands
// are taken one at a time: req.ready is high only while no command is in
// flight.
//
// Each command sweeps the entry RAM from entry 0 upward, one read per cycle
// while the sweep is not paused, evaluating each entry from the registered
// read data. A finish state then writes back the entry that a lookup, insert
// or release updates, and loads the closing response.
//
// Invalidate and purge emit one beat per freed handle during the sweep. One
// freed handle is held back so that last can be set on the true final beat;
// with the output register full and rsp.ready low, the sweep pauses at the
// next freed handle until the receiver takes the waiting beat; none is lost.
//
// Reset clears every valid bit and the round-robin pointer at once; the RAM
// contents stay as they are, since an entry only counts while marked valid.
// There is no clearing pass, so the first command is accepted right after
// reset.
module locked_descriptor_cache (
	input  logic       clk,
	input  logic       arst_n,
	ldc_req_if.sink    req,
	ldc_rsp_if.source  rsp
);

	logic                            out_free;
	logic                            res_load;
	ldc_pkg::rsp_t                   res_data;
	logic                            mem_we;
	logic [ldc_pkg::IDX_W-1:0]       mem_waddr;
	logic [ldc_pkg::ENTRY_W-1:0]     mem_wdata;
	logic                            mem_re;
	logic [ldc_pkg::IDX_W-1:0]       mem_raddr;
	logic [ldc_pkg::ENTRY_W-1:0]     mem_rdata;

	// Keys, lock counts, marks and handles live in one RAM word per slot.
	ldc_ram #(
		.DEPTH(ldc_pkg::ENTRIES),
		.WIDTH(ldc_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The sequencer owns the valid bits, the round-robin pointer and the sweep.
	ldc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.res_load  (res_load),
		.res_data  (res_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// The output register holds a response beat while the receiver stalls.
	ldc_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.data   (res_data),
		.free   (out_free),
		.rsp    (rsp)
	);

endmodule

// ===== bench/locked_descriptor_cache_test.sv =====
// ----------------------------------------------------------------------------
// locked_descriptor_cache_test: self-checking bench of the descriptor cache
// Directed table, pooled random commands, forced eviction and full-lock
// sweeps and a lock-stacking run, scored against typed answers or a shadow cache.
// ----------------------------------------------------------------------------
module locked_descriptor_cache_test;

	// Command codes the block does not decode; they must answer with an empty beat.
	localparam logic [2:0] CMD_UNUSED_A = 3'd5;
	localparam logic [2:0] CMD_UNUSED_B = 3'd6;
	localparam logic [2:0] CMD_UNUSED_C = 3'd7;

	// Cycles without any beat on either channel before the run is declared hung.
	// The limit lies far above the slowest correct gap, receiver stalls included.
	localparam int STALL_LIMIT  = 2000;
	// Quiet time after the last expected beat.
	localparam int DRAIN_CYCLES = 30;
	localparam int FRESH_KEYS   = 18;

	localparam logic [ldc_pkg::LOCK_BITS-1:0] LOCK_CEILING = '1;

	typedef struct {
		ldc_pkg::req_t request;
		bit            typed;
		ldc_pkg::rsp_t answer;
	} probe_t;

	logic clk;
	logic arst_n;

	ldc_req_if req_ch();
	ldc_rsp_if rsp_ch();

	locked_descriptor_cache dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the cache contents and the replacement pointer.
	bit                        shadow_valid [ldc_pkg::ENTRIES];
	ldc_pkg::entry_t           shadow_entry [ldc_pkg::ENTRIES];
	logic [ldc_pkg::IDX_W-1:0] shadow_rr;

	ldc_pkg::rsp_t predicted[$];    // beats of the command just accepted
	ldc_pkg::rsp_t answers_due[$];  // beats still owed by the block, oldest first
	probe_t        probes[$];

	bit idling_on;
	int failures;
	int commands_sent;
	int beats_checked;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic ldc_pkg::req_t command_of(logic [2:0] cmd, logic [31:0] obj,
			logic [7:0] cat, logic [7:0] srv, logic any, logic [31:0] hin);
		ldc_pkg::req_t r;
		r.command          = cmd;
		r.object_number    = obj;
		r.category         = cat;
		r.server_id        = srv;
		r.match_any_object = any;
		r.handle_in        = hin;
		return r;
	endfunction

	function automatic ldc_pkg::rsp_t beat_of(logic hit, logic [31:0] hout, logic stored,
			logic fv, logic [31:0] fh);
		ldc_pkg::rsp_t b;
		b.hit         = hit;
		b.handle_out  = hout;
		b.stored      = stored;
		b.free_valid  = fv;
		b.free_handle = fv ? fh : 32'h0;
		b.last        = 1'b0;
		return b;
	endfunction

	// A typed-in answer is always the single, closing beat of its command.
	function automatic ldc_pkg::rsp_t closing_beat(logic hit, logic [31:0] hout, logic stored,
			logic fv, logic [31:0] fh);
		ldc_pkg::rsp_t b;
		b = beat_of(hit, hout, stored, fv, fh);
		b.last = 1'b1;
		return b;
	endfunction

	// Applies one command to the shadow cache and leaves its beats in predicted.
	function automatic void cache_predict(ldc_pkg::req_t r);
		int i;
		int hit_i;
		int free_i;
		int rr_i;
		int other_i;
		bit evict;
		bit freed;
		bit matched;
		logic [31:0] old_handle;
		predicted = {};
		hit_i = -1;
		free_i = -1;
		rr_i = -1;
		other_i = -1;
		matched = 1'b0;
		case (r.command)
			ldc_pkg::CMD_LOOKUP, ldc_pkg::CMD_INSERT: begin
				for (i = 0; i < ldc_pkg::ENTRIES && hit_i < 0; i++) begin
					if (shadow_valid[i] && shadow_entry[i].object == r.object_number &&
							shadow_entry[i].category == r.category &&
							shadow_entry[i].server == r.server_id)
						hit_i = i;
				end
				if (hit_i >= 0) begin
					// A hit takes one more lock; the count sticks at its ceiling.
					if (shadow_entry[hit_i].lock != LOCK_CEILING)
						shadow_entry[hit_i].lock = shadow_entry[hit_i].lock + 1'b1;
					predicted.push_back(beat_of(1'b1, shadow_entry[hit_i].handle, 1'b0,
						r.command == ldc_pkg::CMD_INSERT, r.handle_in));
				end else if (r.command == ldc_pkg::CMD_LOOKUP) begin
					predicted.push_back(beat_of(1'b0, 32'h0, 1'b0, 1'b0, 32'h0));
				end else begin
					// Highest free slot wins; otherwise the round-robin slot if it is
					// unlocked, else the highest other unlocked slot.
					for (i = 0; i < ldc_pkg::ENTRIES; i++) begin
						if (!shadow_valid[i])
							free_i = i;
						else if (shadow_entry[i].lock == '0) begin
							if (i == int'(shadow_rr))
								rr_i = i;
							else
								other_i = i;
						end
					end
					if (free_i < 0) begin
						shadow_rr = ldc_pkg::IDX_W'((int'(shadow_rr) + 1) % ldc_pkg::ENTRIES);
						free_i = (rr_i >= 0) ? rr_i : other_i;
					end
					if (free_i >= 0) begin
						evict = shadow_valid[free_i];
						old_handle = shadow_entry[free_i].handle;
						shadow_valid[free_i] = 1'b1;
						shadow_entry[free_i].object   = r.object_number;
						shadow_entry[free_i].category = r.category;
						shadow_entry[free_i].server   = r.server_id;
						shadow_entry[free_i].handle   = r.handle_in;
						shadow_entry[free_i].lock     = ldc_pkg::LOCK_BITS'(1);
						shadow_entry[free_i].mark     = 1'b0;
						predicted.push_back(beat_of(1'b0, r.handle_in, 1'b1, evict, old_handle));
					end else begin
						predicted.push_back(beat_of(1'b0, r.handle_in, 1'b0, 1'b0, 32'h0));
					end
				end
			end
			ldc_pkg::CMD_RELEASE: begin
				for (i = 0; i < ldc_pkg::ENTRIES && hit_i < 0; i++) begin
					if (shadow_valid[i] && shadow_entry[i].handle == r.handle_in)
						hit_i = i;
				end
				if (hit_i >= 0) begin
					freed = 1'b0;
					if (shadow_entry[hit_i].lock != '0)
						shadow_entry[hit_i].lock = shadow_entry[hit_i].lock - 1'b1;
					if (shadow_entry[hit_i].lock == '0 && shadow_entry[hit_i].mark) begin
						shadow_valid[hit_i] = 1'b0;
						freed = 1'b1;
					end
					predicted.push_back(beat_of(1'b1, 32'h0, 1'b0, freed,
						shadow_entry[hit_i].handle));
				end else begin
					// An unknown handle goes straight back to the caller to be freed.
					predicted.push_back(beat_of(1'b0, 32'h0, 1'b0, 1'b1, r.handle_in));
				end
			end
			ldc_pkg::CMD_INVALIDATE, ldc_pkg::CMD_PURGE: begin
				for (i = 0; i < ldc_pkg::ENTRIES; i++) begin
					if (!shadow_valid[i] || shadow_entry[i].server != r.server_id)
						continue;
					if (r.command == ldc_pkg::CMD_INVALIDATE &&
							!((r.match_any_object || shadow_entry[i].object == r.object_number) &&
							shadow_entry[i].category == r.category))
						continue;
					matched = 1'b1;
					if (r.command == ldc_pkg::CMD_INVALIDATE && shadow_entry[i].lock != '0) begin
						shadow_entry[i].mark = 1'b1;
					end else if (predicted.size() < ldc_pkg::RESULT_LIMIT) begin
						shadow_valid[i] = 1'b0;
						predicted.push_back(beat_of(1'b1, 32'h0, 1'b0, 1'b1,
							shadow_entry[i].handle));
					end
				end
				if (predicted.size() == 0)
					predicted.push_back(beat_of(matched, 32'h0, 1'b0, 1'b0, 32'h0));
			end
			default: begin
				predicted.push_back(beat_of(1'b0, 32'h0, 1'b0, 1'b0, 32'h0));
			end
		endcase
		predicted[predicted.size() - 1].last = 1'b1;
	endfunction

	// Presents one command beat from the falling edge and holds it until the
	// block takes it. Valid is left high, so back-to-back commands never see
	// valid dropped and raised within one time step.
	task automatic send_command(ldc_pkg::req_t r, bit typed, ldc_pkg::rsp_t typed_beat);
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		cache_predict(r);
		if (typed)
			answers_due.push_back(typed_beat);
		else
			foreach (predicted[k]) answers_due.push_back(predicted[k]);
		commands_sent++;
	endtask

	task automatic send_checked(ldc_pkg::req_t r);
		send_command(r, 1'b0, '0);
	endtask

	// Now and then the sender drops valid for a burst of random length.
	task automatic sender_gap();
		int n;
		if (!idling_on || $urandom_range(0, 3) != 0)
			return;
		n = $urandom_range(1, 5);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Holds off the sender until every owed beat has come back.
	task automatic wait_for_answers();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			failures++;
			$error("%s: expected %h, got %h", name, want, got);
		end
	endfunction

	// The receiver stalls in bursts while idling is on and is always ready otherwise.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Scores every response beat against the oldest owed beat and watches for
	// a hung block. Sampling at the rising edge sees the values of the cycle
	// that is ending, before any register of the block updates.
	always @(posedge clk) begin : scoreboard
		ldc_pkg::rsp_t seen;
		ldc_pkg::rsp_t want;
		bit            req_beat;
		bit            rsp_beat;
		req_beat = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
		rsp_beat = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);
		if (rsp_beat) begin
			seen = rsp_ch.payload;
			beats_checked++;
			if (answers_due.size() == 0) begin
				failures++;
				$error("response beat with nothing expected: %p", seen);
			end else begin
				want = answers_due.pop_front();
				check_field("hit", want.hit, seen.hit);
				check_field("handle_out", want.handle_out, seen.handle_out);
				check_field("stored", want.stored, seen.stored);
				check_field("free_valid", want.free_valid, seen.free_valid);
				check_field("free_handle", want.free_handle, seen.free_handle);
				check_field("last", want.last, seen.last);
			end
		end
		if (req_beat || rsp_beat)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d beats still owed",
				STALL_LIMIT, answers_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		ldc_pkg::req_t r;
		int            i;
		int            pick;
		logic [31:0]   obj_pool [8];
		logic [7:0]    cat_pool [3];
		logic [7:0]    srv_pool [2];
		logic [31:0]   handle_pool [12];
		logic [31:0]   fresh_handle [FRESH_KEYS];
		logic [31:0]   sat_object;
		logic [31:0]   sat_handle;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		idling_on = 1'b1;
		failures = 0;
		commands_sent = 0;
		beats_checked = 0;
		quiet_cycles = 0;
		for (i = 0; i < ldc_pkg::ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_entry[i] = '0;
		end
		shadow_rr = '0;

		// Small key and handle pools make hits, duplicate handles and refills
		// likely; the extremes of the object number sit in the pool as well.
		obj_pool[0] = 32'h0;
		obj_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < 8; i++)
			obj_pool[i] = $urandom;
		for (i = 0; i < 3; i++)
			cat_pool[i] = 8'($urandom);
		srv_pool[0] = 8'($urandom);
		srv_pool[1] = srv_pool[0] ^ 8'h5A;
		for (i = 0; i < 12; i++)
			handle_pool[i] = $urandom;

		// Directed table. Answers are typed in where they follow from an empty
		// cache or from a single entry; the rest comes from the shadow cache.
		// Empty cache: lookup miss, release of an unknown handle, nothing to
		// invalidate or purge, and the three undecoded commands.
		probes.push_back('{command_of(ldc_pkg::CMD_LOOKUP, 32'h0, 8'h00, 8'h00, 1'b0, 32'h0),
			1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0,
			32'hFFFF_FFFF), 1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF)});
		probes.push_back('{command_of(ldc_pkg::CMD_INVALIDATE, 32'h0, 8'h00, 8'h00, 1'b1,
			32'h0), 1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(ldc_pkg::CMD_PURGE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1,
			32'h0), 1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(CMD_UNUSED_A, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1,
			32'hFFFF_FFFF), 1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(CMD_UNUSED_B, 32'h0, 8'h00, 8'h00, 1'b0, 32'h0), 1'b1,
			closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(CMD_UNUSED_C, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1,
			32'hFFFF_FFFF), 1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		// All-ones key: insert miss into a free slot, insert hit that discards
		// the new handle, then a lookup hit.
		probes.push_back('{command_of(ldc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0,
			32'h0000_0001), 1'b1, closing_beat(1'b0, 32'h0000_0001, 1'b1, 1'b0, 32'h0)});
		probes.push_back('{command_of(ldc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0,
			32'hFFFF_FFFF), 1'b1, closing_beat(1'b1, 32'h0000_0001, 1'b0, 1'b1, 32'hFFFF_FFFF)});
		probes.push_back('{command_of(ldc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0,
			32'h0), 1'b1, closing_beat(1'b1, 32'h0000_0001, 1'b0, 1'b0, 32'h0)});
		// All-zero key with a zero handle, and a key that differs only in server.
		probes.push_back('{command_of(ldc_pkg::CMD_INSERT, 32'h0, 8'h00, 8'h00, 1'b0, 32'h0),
			1'b1, closing_beat(1'b0, 32'h0, 1'b1, 1'b0, 32'h0)});
		probes.push_back('{command_of(ldc_pkg::CMD_LOOKUP, 32'h0, 8'h00, 8'hFF, 1'b0, 32'h0),
			1'b1, closing_beat(1'b0, 32'h0, 1'b0, 1'b0, 32'h0)});
		// Invalidating a locked entry only marks it; the entry goes away when the
		// third release brings its lock count to zero.
		probes.push_back('{command_of(ldc_pkg::CMD_INVALIDATE, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
			1'b0, 32'h0), 1'b1, closing_beat(1'b1, 32'h0, 1'b0, 1'b0, 32'h0)});
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0,
			32'h0000_0001), 1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0,
			32'h0000_0001), 1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0,
			32'h0000_0001), 1'b0, '0});
		// Unlocked and unmarked: stays. A wildcard invalidate then frees it.
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0, 32'h0),
			1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_INVALIDATE, 32'h1234_5678, 8'h00, 8'h00,
			1'b1, 32'h0), 1'b0, '0});
		// Purge frees locked entries too, one beat each.
		probes.push_back('{command_of(ldc_pkg::CMD_INSERT, 32'h5A5A_5A5A, 8'h0F, 8'h01, 1'b0,
			32'hA5A5_A5A5), 1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_INSERT, 32'hA5A5_A5A5, 8'hF0, 8'h01, 1'b0,
			32'h5A5A_5A5A), 1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_PURGE, 32'h0, 8'h00, 8'h01, 1'b0, 32'h0),
			1'b0, '0});
		probes.push_back('{command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h01, 1'b0,
			32'hA5A5_A5A5), 1'b0, '0});

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (probes[k]) begin
			sender_gap();
			send_command(probes[k].request, probes[k].typed, probes[k].answer);
		end

		// Pooled random commands, mostly well formed, with some raw noise that
		// also reaches the undecoded command codes.
		for (i = 0; i < 10; i++) begin
			pick = $urandom_range(0, 99);
			r = command_of(ldc_pkg::CMD_INSERT, obj_pool[$urandom_range(0, 7)],
				cat_pool[$urandom_range(0, 2)], srv_pool[$urandom_range(0, 1)],
				1'($urandom_range(0, 1)), handle_pool[$urandom_range(0, 11)]);
			if (pick < 15)
				r.command = ldc_pkg::CMD_LOOKUP;
			else if (pick < 40)
				r.command = ldc_pkg::CMD_RELEASE;
			else if (pick < 50)
				r.command = ldc_pkg::CMD_INVALIDATE;
			else if (pick < 55)
				r.command = ldc_pkg::CMD_PURGE;
			else if (pick < 63)
				r = command_of(3'($urandom_range(0, 7)), $urandom, 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)), $urandom);
			sender_gap();
			send_checked(r);
		end

		// The sender waits here until the block has answered everything.
		wait_for_answers();

		// Fresh keys overrun the cache: every slot ends up locked and the last
		// inserts cannot be stored.
		for (i = 0; i < FRESH_KEYS; i++) begin
			fresh_handle[i] = $urandom;
			sender_gap();
			send_checked(command_of(ldc_pkg::CMD_INSERT, $urandom, cat_pool[$urandom_range(0, 2)],
				srv_pool[$urandom_range(0, 1)], 1'b0, fresh_handle[i]));
		end
		// Unlock them again; the handles that never got a slot come back freed.
		for (i = 0; i < FRESH_KEYS; i++) begin
			sender_gap();
			send_checked(command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0,
				fresh_handle[i]));
		end

		// From here on both sides run flat out.
		idling_on = 1'b0;

		// A full cache of unlocked entries: new keys now evict through the
		// round-robin pointer.
		for (i = 0; i < FRESH_KEYS; i++)
			send_checked(command_of(ldc_pkg::CMD_INSERT, $urandom, cat_pool[$urandom_range(0, 2)],
				srv_pool[$urandom_range(0, 1)], 1'b0, $urandom));
		for (i = 0; i < 6; i++)
			send_checked(command_of(ldc_pkg::CMD_INVALIDATE, $urandom, cat_pool[i % 3],
				srv_pool[i / 3], 1'b1, $urandom));
		for (i = 0; i < 2; i++)
			send_checked(command_of(ldc_pkg::CMD_PURGE, $urandom, 8'($urandom), srv_pool[i],
				1'b0, $urandom));

		// Stack several locks on one entry. The invalidate below then only marks
		// it, one release leaves it locked and marked, and the purge frees it.
		sat_object = $urandom;
		sat_handle = $urandom;
		send_checked(command_of(ldc_pkg::CMD_INSERT, sat_object, cat_pool[0], srv_pool[0], 1'b0,
			sat_handle));
		repeat (3)
			send_checked(command_of(ldc_pkg::CMD_LOOKUP, sat_object, cat_pool[0], srv_pool[0],
				1'b0, 32'h0));
		send_checked(command_of(ldc_pkg::CMD_INVALIDATE, sat_object, cat_pool[0], srv_pool[0],
			1'b0, 32'h0));
		send_checked(command_of(ldc_pkg::CMD_RELEASE, 32'h0, 8'h00, 8'h00, 1'b0, sat_handle));
		send_checked(command_of(ldc_pkg::CMD_PURGE, 32'h0, 8'h00, srv_pool[0], 1'b0, 32'h0));

		wait_for_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands: directed corner cases, pooled random traffic,",
			commands_sent);
		$display("full-lock and eviction sweeps, and lock stacking; %0d beats scored.",
			beats_checked);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ldc_pkg.sv
rtl/core/ldc_if.sv
rtl/core/ldc_ram.sv
rtl/core/ldc_out_reg.sv
rtl/core/ldc_ctrl.sv
rtl/core/locked_descriptor_cache.sv
bench/locked_descriptor_cache_test.sv
